@@ rtl/sgm_pkg.sv @@
// Shared types and constants for the Sobel gradient magnitude block.
// No dependencies; imported by sgm_isqrt and the top level.
`default_nettype none

package sgm_pkg;

  localparam int MAX_WIDTH  = 2048;
  localparam int MAX_HEIGHT = 2048;

  localparam int PIX_W      = 8;
  localparam int DIM_W      = 12;                       // config register width
  localparam int COL_W      = $clog2(MAX_WIDTH);        // column < width
  localparam int ROW_W      = $clog2(MAX_HEIGHT + 2);   // rows run to height+1
  localparam int CFG_IDX_W  = 2;

  // Gradient: |G| <= 4*255, signed
  localparam int GRAD_W     = PIX_W + 3;
  localparam int SQ_W       = 2 * GRAD_W;               // Gx^2 + Gy^2 fits here
  localparam int ROOT_W     = SQ_W / 2;
  localparam int ROOT_STEPS = ROOT_W;
  localparam int STEP_W     = $clog2(ROOT_STEPS);
  localparam int REM_W      = ROOT_W + 2;

  localparam int LINE_W     = 2 * PIX_W;                // {upper, middle} per column

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_IMAGE_WIDTH,
    REG_IMAGE_HEIGHT
  } cfg_reg_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_LOAD,
    S_GRAD,
    S_ROOT,
    S_OUT
  } sgm_state_t;

  typedef struct packed {
    logic             mode;
    logic [PIX_W-1:0] pixel;
  } pix_word_t;

  typedef struct packed {
    logic [PIX_W-1:0] magnitude;
    logic             frame_end;
  } res_word_t;

endpackage

`default_nettype wire

@@ rtl/sgm_ram.sv @@
// Generic simple dual-port RAM, one write port, one registered read port.
// No dependencies.
`default_nettype none

module sgm_ram #(
  parameter int WIDTH  = 8,
  parameter int DEPTH  = 2048,
  parameter int ADDR_W = $clog2(DEPTH)
) (
  input  wire logic              clk,
  input  wire logic              wr_en,
  input  wire logic [ADDR_W-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]  wr_data,
  input  wire logic              rd_en,
  input  wire logic [ADDR_W-1:0] rd_addr,
  output      logic [WIDTH-1:0]  rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

@@ rtl/sgm_isqrt.sv @@
// Iterative integer square root, one result bit per cycle.
// Depends on sgm_pkg.
`default_nettype none

module sgm_isqrt
  import sgm_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              start,
  input  wire logic [SQ_W-1:0]   radicand,
  output      logic              done,
  output      logic [ROOT_W-1:0] root
);

  logic              busy;
  logic [STEP_W-1:0] count;
  logic [SQ_W-1:0]   rad;
  logic [REM_W-1:0]  rem;

  logic [REM_W+1:0]  rem_sh;
  logic [REM_W+1:0]  sub;
  logic              fits;

  // bring down two bits, try subtracting 4*root+1
  assign rem_sh = {rem, rad[SQ_W-1 -: 2]};
  assign sub    = {(REM_W - ROOT_W)'(0), root, 2'b01};
  assign fits   = (rem_sh >= sub);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= busy && (count == '0);
      if (start) begin
        busy <= 1'b1;
      end else if (busy && count == '0) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rad   <= radicand;
      rem   <= '0;
      root  <= '0;
      count <= STEP_W'(ROOT_STEPS - 1);
    end else if (busy) begin
      rad   <= {rad[SQ_W-3:0], 2'b00};
      count <= count - 1'b1;
      if (fits) begin
        rem  <= REM_W'(rem_sh - sub);
        root <= {root[ROOT_W-2:0], 1'b1};
      end else begin
        rem  <= rem_sh[REM_W-1:0];
        root <= {root[ROOT_W-2:0], 1'b0};
      end
    end
  end

endmodule

`default_nettype wire

@@ rtl/sobel_gradient_magnitude.sv @@
// Top level of the streaming 3x3 Sobel gradient magnitude block.
// Depends on sgm_pkg, sgm_ram and sgm_isqrt.
//
// Usage:
//  - pix channel (pix_valid / pix_stall / pix_word): grey pixels in raster
//    order. mode=1 marks a padding word; after each frame send width+1
//    padding words to flush the line lag.
//  - res channel (res_valid / res_stall / res_word): one word per item past
//    the warm-up; magnitude is the low 8 bits of floor(sqrt(Gx^2+Gy^2)),
//    0 on the frame border; frame_end flags the last word of a frame.
//    Results trail the pixel stream by width+1 words.
//  - cfg channel (cfg_valid / cfg_ready / cfg_index / cfg_data): index 0 is
//    image width, index 1 image height; values are clamped to [3, 2048].
//    Writing either register restarts the frame position; other indexes
//    are ignored. Write only while idle.
// Sequence: one word at a time. An interior pixel runs from acceptance
// through window update, gradient, 11 square root iterations, a wait to
// see them done and output load, back to the idle state that accepts the
// next. Border pixels skip gradient and root; warm-up words also skip load.
// The output register decouples the sides: the next pixel is accepted
// while a result waits; a held result stalls only the final load.
// Reset: synchronous, returns to frame start with 640x480; line memory
// contents are not cleared (unwritten entries never reach a result).
`default_nettype none

module sobel_gradient_magnitude
  import sgm_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst,
  // pixel input
  input  wire logic                 pix_valid,
  output      logic                 pix_stall,
  input  wire pix_word_t            pix_word,
  // result output
  output      logic                 res_valid,
  input  wire logic                 res_stall,
  output      res_word_t            res_word,
  // register writes
  input  wire logic                 cfg_valid,
  output      logic                 cfg_ready,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [DIM_W-1:0]     cfg_data
);

  sgm_state_t state, state_next;

  logic [DIM_W-1:0] image_width;
  logic [DIM_W-1:0] image_height;
  logic [DIM_W-1:0] w_use;
  logic [DIM_W-1:0] h_use;

  // frame position of the next word
  logic [COL_W-1:0] col;
  logic [ROW_W-1:0] row;

  // per-word latched info
  logic [COL_W-1:0] col_q;
  logic [PIX_W-1:0] px_q;
  logic             has_res;
  logic             interior;
  logic             last;

  logic [PIX_W-1:0] win [9];

  logic              accept;
  logic              cfg_wr;
  logic              mem_wr;
  logic              sqrt_start;
  logic              res_load;
  logic              sqrt_done;
  logic [ROOT_W-1:0] root;
  logic [LINE_W-1:0] line_rd;
  logic [PIX_W-1:0]  top_px;
  logic [PIX_W-1:0]  mid_px;

  // Effective frame size
  always_comb begin
    if (image_width < DIM_W'(3))                w_use = DIM_W'(3);
    else if (image_width > DIM_W'(MAX_WIDTH))   w_use = DIM_W'(MAX_WIDTH);
    else                                        w_use = image_width;
    if (image_height < DIM_W'(3))               h_use = DIM_W'(3);
    else if (image_height > DIM_W'(MAX_HEIGHT)) h_use = DIM_W'(MAX_HEIGHT);
    else                                        h_use = image_height;
  end

  assign cfg_ready = 1'b1;
  assign cfg_wr    = cfg_valid && cfg_ready;
  assign accept    = pix_valid && !pix_stall;

  // Position bookkeeping at acceptance
  logic             c_zero;
  logic             has_res_d;
  logic             interior_d;
  logic             last_d;
  logic [PIX_W-1:0] px_d;
  logic [DIM_W-1:0] col_inc;
  logic             row_wrap;

  always_comb begin
    c_zero     = (col == '0);
    has_res_d  = c_zero ? (row >= ROW_W'(2)) : (row >= ROW_W'(1));
    // output is at (row-1, col-1); column 0 maps to the previous row's last column
    interior_d = !c_zero && (col >= COL_W'(2)) && (row >= ROW_W'(2))
                 && (row <= ROW_W'(h_use - 1'b1));
    last_d     = (row > ROW_W'(h_use));
    px_d       = (pix_word.mode || row >= ROW_W'(h_use)) ? '0 : pix_word.pixel;
    col_inc    = DIM_W'(col) + 1'b1;
    row_wrap   = (col_inc >= w_use);
  end

  // Line memory: each column holds {two rows up, one row up}
  assign {top_px, mid_px} = line_rd;

  sgm_ram #(
    .WIDTH (LINE_W),
    .DEPTH (MAX_WIDTH)
  ) u_line_ram (
    .clk     (clk),
    .wr_en   (mem_wr),
    .wr_addr (col_q),
    .wr_data ({mid_px, px_q}),
    .rd_en   (accept),
    .rd_addr (col),
    .rd_data (line_rd)
  );

  // Registers and position
  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= DIM_W'(640);
      image_height <= DIM_W'(480);
      col          <= '0;
      row          <= '0;
    end else if (cfg_wr) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_IMAGE_WIDTH: begin
          image_width <= cfg_data;
          col         <= '0;
          row         <= '0;
        end
        REG_IMAGE_HEIGHT: begin
          image_height <= cfg_data;
          col          <= '0;
          row          <= '0;
        end
        default: ;
      endcase
    end else if (accept) begin
      if (last_d) begin
        col <= '0;
        row <= '0;
      end else if (row_wrap) begin
        col <= '0;
        row <= row + 1'b1;
      end else begin
        col <= col_inc[COL_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      col_q    <= col;
      px_q     <= px_d;
      has_res  <= has_res_d;
      interior <= interior_d;
      last     <= last_d;
    end
  end

  // 3x3 window shifts left with the new column on the right
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 9; i++) win[i] <= '0;
    end else if (mem_wr) begin
      win[0] <= win[1]; win[1] <= win[2]; win[2] <= top_px;
      win[3] <= win[4]; win[4] <= win[5]; win[5] <= mid_px;
      win[6] <= win[7]; win[7] <= win[8]; win[8] <= px_q;
    end
  end

  // Gradients and squared magnitude
  logic        [PIX_W+1:0]  s_top, s_bot, s_left, s_right;
  logic signed [GRAD_W-1:0] gx, gy;
  logic signed [SQ_W-1:0]   gx_sq, gy_sq;
  logic        [SQ_W-1:0]   sq_sum;

  always_comb begin
    s_top   = {2'b00, win[0]} + {1'b0, win[1], 1'b0} + {2'b00, win[2]};
    s_bot   = {2'b00, win[6]} + {1'b0, win[7], 1'b0} + {2'b00, win[8]};
    s_left  = {2'b00, win[0]} + {1'b0, win[3], 1'b0} + {2'b00, win[6]};
    s_right = {2'b00, win[2]} + {1'b0, win[5], 1'b0} + {2'b00, win[8]};
    gx      = $signed({1'b0, s_top})  - $signed({1'b0, s_bot});
    gy      = $signed({1'b0, s_left}) - $signed({1'b0, s_right});
    gx_sq   = gx * gx;
    gy_sq   = gy * gy;
    sq_sum  = unsigned'(gx_sq) + unsigned'(gy_sq);
  end

  sgm_isqrt u_isqrt (
    .clk      (clk),
    .rst      (rst),
    .start    (sqrt_start),
    .radicand (sq_sum),
    .done     (sqrt_done),
    .root     (root)
  );

  // Sequencer: next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: if (accept) state_next = S_LOAD;
      S_LOAD: begin
        if (!has_res)      state_next = S_IDLE;
        else if (interior) state_next = S_GRAD;
        else               state_next = S_OUT;
      end
      S_GRAD: state_next = S_ROOT;
      S_ROOT: if (sqrt_done) state_next = S_OUT;
      S_OUT:  if (!res_valid || !res_stall) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  // Sequencer: outputs
  always_comb begin
    pix_stall  = 1'b1;
    mem_wr     = 1'b0;
    sqrt_start = 1'b0;
    res_load   = 1'b0;
    unique case (state)
      S_IDLE: pix_stall  = 1'b0;
      S_LOAD: mem_wr     = 1'b1;
      S_GRAD: sqrt_start = 1'b1;
      S_ROOT: ;
      S_OUT:  res_load   = !res_valid || !res_stall;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (res_load) begin
      res_valid <= 1'b1;
    end else if (!res_stall) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      res_word.magnitude <= interior ? root[PIX_W-1:0] : '0;
      res_word.frame_end <= last;
    end
  end

endmodule

`default_nettype wire
